// File: hw/rtl/gcw_pkg.sv
package gcw_pkg;

   // panel geometry
   localparam int COLUMNS_PER_SIDE = 64;
   localparam int PAGE_COUNT       = 8;
   localparam int COL_LAST         = 2 * COLUMNS_PER_SIDE - 1;
   localparam int PAGE_LAST        = PAGE_COUNT - 1;
   localparam int COL_W            = $clog2(2 * COLUMNS_PER_SIDE);
   localparam int PAGE_W           = $clog2(PAGE_COUNT);

   // descriptor queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request kinds
   typedef enum logic [1:0] {
      KIND_GOTO  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_INIT  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // configuration register indexes
   localparam logic [1:0] CSR_PAGE_CMD_BASE   = 2'd0;
   localparam logic [1:0] CSR_COLUMN_CMD_BASE = 2'd1;
   localparam logic [1:0] CSR_START_LINE_CMD  = 2'd2;
   localparam logic [1:0] CSR_DISPLAY_ON_CMD  = 2'd3;

   // chip select codes
   localparam logic [1:0] CS_LEFT  = 2'd1;
   localparam logic [1:0] CS_RIGHT = 2'd2;
   localparam logic [1:0] CS_BOTH  = 2'd3;

   // bus transaction steps of one run, one-hot, emitted lowest first
   localparam int STEP_COUNT = 7;
   typedef enum logic [STEP_COUNT-1:0] {
      STEP_DATA   = 7'b0000001,
      STEP_A_PAGE = 7'b0000010,
      STEP_A_COL  = 7'b0000100,
      STEP_B_PAGE = 7'b0001000,
      STEP_B_COL  = 7'b0010000,
      STEP_START  = 7'b0100000,
      STEP_DON    = 7'b1000000
   } step_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] target_page;
      logic [7:0] target_column;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic [1:0] chip_select;
      logic [7:0] bus_value;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] page_cmd_base;
      logic [7:0] column_cmd_base;
      logic [7:0] start_line_cmd;
      logic [7:0] display_on_cmd;
   } cfg_type;

   // one classified request: which steps to emit and their operands
   typedef struct packed {
      logic [STEP_COUNT-1:0] steps;
      logic                  data_side;
      logic [7:0]            pixel_byte;
      logic [PAGE_W-1:0]     a_page;
      logic [COL_W-1:0]      a_col;
      logic [PAGE_W-1:0]     b_page;
      logic [COL_W-1:0]      b_col;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // side of the panel that a column is on (0 left, 1 right)
   function automatic logic side_of(input logic [COL_W-1:0] col);
      return col >= COL_W'(COLUMNS_PER_SIDE);
   endfunction

   // column relative to its chip, widened to the bus
   function automatic logic [7:0] rel_col(input logic [COL_W-1:0] col);
      logic [COL_W-1:0] r;
      r = side_of(col) ? col - COL_W'(COLUMNS_PER_SIDE) : col;
      return 8'(r);
   endfunction

endpackage

// File: hw/rtl/gcw_front.sv
module gcw_front import gcw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   output logic     push,
   output desc_type desc
);

   logic [PAGE_W-1:0] page_ff, page_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              active_ff, active_in;
   logic              prev_ff, prev_in;

   logic [PAGE_W-1:0] goto_page;
   logic [COL_W-1:0]  goto_col;
   logic [COL_W:0]    col_step;
   logic              wrap;
   logic              new_side;

   // clamp the goto target
   always_comb begin
      goto_page = (req.target_page > 8'(PAGE_LAST)) ? PAGE_W'(PAGE_LAST)
                                                    : PAGE_W'(req.target_page);
      goto_col  = (req.target_column > 8'(COL_LAST)) ? COL_W'(COL_LAST)
                                                     : COL_W'(req.target_column);
   end

   // cursor update and run classification
   always_comb begin
      page_in   = page_ff;
      col_in    = col_ff;
      active_in = active_ff;
      prev_in   = prev_ff;
      col_step  = {1'b0, col_ff} + (COL_W+1)'(1);
      wrap      = col_step > (COL_W+1)'(COL_LAST);
      new_side  = 1'b0;
      push      = 1'b0;
      desc      = '0;
      desc.pixel_byte = req.pixel_byte;
      desc.data_side  = active_ff;
      case (kind_type'(req.kind))
         KIND_GOTO: begin
            push        = accept;
            page_in     = goto_page;
            col_in      = goto_col;
            active_in   = side_of(goto_col);
            desc.steps  = STEP_A_PAGE | STEP_A_COL;
            desc.a_page = goto_page;
            desc.a_col  = goto_col;
         end
         KIND_WRITE: begin
            push       = accept;
            desc.steps = STEP_DATA;
            if (wrap) begin
               page_in     = (page_ff == PAGE_W'(PAGE_LAST)) ? page_ff
                                                            : page_ff + PAGE_W'(1);
               col_in      = '0;
               desc.steps  = desc.steps | STEP_A_PAGE | STEP_A_COL;
               desc.a_page = page_in;
               desc.a_col  = '0;
            end else begin
               col_in = col_step[COL_W-1:0];
            end
            new_side  = side_of(col_in);
            active_in = new_side;
            // crossing to the other chip re-sends the address
            if (prev_ff != new_side) begin
               prev_in     = new_side;
               desc.steps  = desc.steps | STEP_B_PAGE | STEP_B_COL;
               desc.b_page = page_in;
               desc.b_col  = col_in;
            end
         end
         KIND_INIT: begin
            push        = accept;
            page_in     = '0;
            col_in      = '0;
            active_in   = 1'b0;
            desc.steps  = STEP_A_PAGE | STEP_A_COL | STEP_START | STEP_DON;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff   <= '0;
         col_ff    <= '0;
         active_ff <= 1'b0;
         prev_ff   <= 1'b0;
      end else if (accept) begin
         page_ff   <= page_in;
         col_ff    <= col_in;
         active_ff <= active_in;
         prev_ff   <= prev_in;
      end
   end

endmodule

// File: hw/rtl/gcw_queue.sv
module gcw_queue import gcw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_desc,
   input  logic             pop,
   output desc_type         head,
   output queue_status_type status
);

   desc_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: hw/rtl/gcw_back.sv
module gcw_back import gcw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  desc_type head,
   input  logic     head_valid,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   logic [STEP_COUNT-1:0] done_ff, done_in;
   logic                  valid_ff, valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [STEP_COUNT-1:0] remaining;
   logic [STEP_COUNT-1:0] cur;
   logic                  last;
   logic                  fire;

   // pick the next step of the head run
   always_comb begin
      remaining = head.steps & ~done_ff;
      cur       = remaining & (~remaining + STEP_COUNT'(1));
      last      = (remaining & ~cur) == '0;
      fire      = head_valid && (!valid_ff || !rsp_stall);
      pop       = fire && last;
   end

   // build the bus transaction for that step
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.last_of_run = last;
      case (step_type'(cur))
         STEP_DATA: begin
            rsp_in.is_data     = 1'b1;
            rsp_in.chip_select = head.data_side ? CS_RIGHT : CS_LEFT;
            rsp_in.bus_value   = head.pixel_byte;
         end
         STEP_A_PAGE: begin
            rsp_in.is_data     = 1'b0;
            rsp_in.chip_select = side_of(head.a_col) ? CS_RIGHT : CS_LEFT;
            rsp_in.bus_value   = cfg.page_cmd_base + 8'(head.a_page);
         end
         STEP_A_COL: begin
            rsp_in.is_data     = 1'b0;
            rsp_in.chip_select = side_of(head.a_col) ? CS_RIGHT : CS_LEFT;
            rsp_in.bus_value   = cfg.column_cmd_base + rel_col(head.a_col);
         end
         STEP_B_PAGE: begin
            rsp_in.is_data     = 1'b0;
            rsp_in.chip_select = side_of(head.b_col) ? CS_RIGHT : CS_LEFT;
            rsp_in.bus_value   = cfg.page_cmd_base + 8'(head.b_page);
         end
         STEP_B_COL: begin
            rsp_in.is_data     = 1'b0;
            rsp_in.chip_select = side_of(head.b_col) ? CS_RIGHT : CS_LEFT;
            rsp_in.bus_value   = cfg.column_cmd_base + rel_col(head.b_col);
         end
         STEP_START: begin
            rsp_in.is_data     = 1'b0;
            rsp_in.chip_select = CS_BOTH;
            rsp_in.bus_value   = cfg.start_line_cmd;
         end
         STEP_DON: begin
            rsp_in.is_data     = 1'b0;
            rsp_in.chip_select = CS_BOTH;
            rsp_in.bus_value   = cfg.display_on_cmd;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // step progress and output register handshake
   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff && rsp_stall;
      if (fire) begin
         valid_in = 1'b1;
         done_in  = last ? '0 : (done_ff | cur);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/dual_chip_glcd_cursor_writer.sv
// Cursor writer for a panel of two column controller chips. Each request item
// (goto, data write, init) is turned into a run of 1 to 5 bus transactions on
// the rsp channel, one per cycle while rsp_stall is low; last_of_run marks the
// end of each run. A goto yields 2 transactions, an init 4, and a data write
// 1, 3 or 5 (the address is re-sent on a page wrap and again when the cursor
// changes chip). The front takes one request per cycle while req_stall is low
// and updates the cursor at once; a two-entry run queue sits between it and the
// transaction sequencer, so the sustained rate is set by the sequencer. Kind 3
// requests are accepted and produce nothing. The command registers are written
// through the csr port; the user must do so only while no run is pending, which
// the block does not enforce. They reset to the usual controller command codes.
module dual_chip_glcd_cursor_writer import gcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   cfg_type          cfg_ff, cfg_in;
   logic             accept;
   logic             push;
   logic             pop;
   desc_type         push_desc;
   desc_type         head;
   queue_status_type q_status;

   // command registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PAGE_CMD_BASE:   cfg_in.page_cmd_base   = csr_write_data;
            CSR_COLUMN_CMD_BASE: cfg_in.column_cmd_base = csr_write_data;
            CSR_START_LINE_CMD:  cfg_in.start_line_cmd  = csr_write_data;
            CSR_DISPLAY_ON_CMD:  cfg_in.display_on_cmd  = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_cmd_base   <= 8'd184;
         cfg_ff.column_cmd_base <= 8'd64;
         cfg_ff.start_line_cmd  <= 8'd192;
         cfg_ff.display_on_cmd  <= 8'd63;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   gcw_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .desc   (push_desc)
   );

   gcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   gcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .head_valid  (!q_status.empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // run queue never overflows or underflows
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("run queue overflow");
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("run queue underflow");

   // every transaction selects a chip, data never goes to both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.chip_select != 2'd0)
      else $error("transaction with no chip selected");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_data |-> rsp_payload.chip_select != CS_BOTH)
      else $error("data transfer sent to both chips");

endmodule
